// ----- src/fsfl_pkg.sv -----
// Shared constants, codes and types of the fixed-slot free-list allocator.
// Used by the channel interfaces, the top level and the testbench.
// No dependencies.
package fsfl_pkg;

	localparam int MAX_SLOTS = 256;
	localparam int SLOT_W    = $clog2(MAX_SLOTS);
	localparam int LINK_W    = SLOT_W + 1;

	// Field widths of the channels and the configuration register.
	localparam int CMD_W      = 2;
	localparam int SLOT_IN_W  = 8;
	localparam int STATUS_W   = 2;
	localparam int SLOT_OUT_W = 8;
	localparam int USED_W     = 9;
	localparam int CFG_W      = 9;

	localparam int CMP_W = (LINK_W > SLOT_IN_W) ? LINK_W : SLOT_IN_W;

	typedef logic [CMD_W-1:0]    cmd_t;
	typedef logic [STATUS_W-1:0] status_t;
	typedef logic [LINK_W-1:0]   link_t;
	typedef logic [SLOT_W-1:0]   addr_t;

	localparam cmd_t CMD_ALLOC  = 2'd0;
	localparam cmd_t CMD_FREE   = 2'd1;
	localparam cmd_t CMD_REINIT = 2'd2;

	localparam status_t ST_OK        = 2'd0;
	localparam status_t ST_EXHAUSTED = 2'd1;
	localparam status_t ST_NONE_USED = 2'd2;
	localparam status_t ST_RANGE     = 2'd3;

endpackage

// ----- src/fsfl_if.sv -----
// Valid/ready channel interfaces of the allocator: command in, response out.
// Depends on fsfl_pkg for the field widths.
interface fsfl_cmd_if;
	import fsfl_pkg::*;
	logic                 valid;
	logic                 ready;
	logic [CMD_W-1:0]     command;
	logic [SLOT_IN_W-1:0] slot_in;

	modport source (output valid, output command, output slot_in, input ready);
	modport sink (input valid, input command, input slot_in, output ready);
endinterface

interface fsfl_rsp_if;
	import fsfl_pkg::*;
	logic                  valid;
	logic                  ready;
	logic [STATUS_W-1:0]   status;
	logic [SLOT_OUT_W-1:0] slot_out;
	logic [USED_W-1:0]     used_count;

	modport source (output valid, output status, output slot_out, output used_count,
		input ready);
	modport sink (input valid, input status, input slot_out, input used_count,
		output ready);
endinterface

// ----- src/fsfl_ram.sv -----
// Generic single-write, single-read RAM with a registered read port.
// No dependencies.
module fsfl_ram #(
	parameter int WIDTH = 9,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule

// ----- src/fixed_slot_free_list_allocator.sv -----
// The allocator accepts one command per clock and returns its response beat in the output
// register on the next cycle; a new command is taken while a response waits, as long as the
// response side is ready or the register is empty. The rate is set by the head-link
// register: the successor of the free-list head is kept at hand, and after an allocate it
// is fetched from the link RAM whose registered read lands exactly when the next command
// needs it. Links never written since reset, reinit or a pool_slots write read as their
// index plus one through per-slot valid bits, so there is no clearing pass. Writing
// pool_slots reinitializes the pool; do it only while no command is in flight.
// Depends on fsfl_pkg, fsfl_if and fsfl_ram.
module fixed_slot_free_list_allocator (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       cfg_we,
	input  logic [fsfl_pkg::CFG_W-1:0] cfg_wdata,
	fsfl_cmd_if.sink                   cmd,
	fsfl_rsp_if.source                 rsp
);
	import fsfl_pkg::*;

	link_t                count_q;
	link_t                used_q;
	link_t                head_q;
	link_t                link_q;
	logic                 from_ram_q;
	logic [MAX_SLOTS-1:0] valid_q;

	logic  rd_vld_q;
	addr_t rd_addr_q;
	logic  rd_beyond_q;

	logic                  out_valid_q;
	status_t               status_q;
	logic [SLOT_OUT_W-1:0] slot_out_q;
	logic [USED_W-1:0]     used_out_q;

	logic    accept;
	link_t   rd_data;
	link_t   ram_link;
	link_t   link_cur;
	link_t   head_d;
	link_t   link_d;
	link_t   used_d;
	link_t   got;
	link_t   count_d;
	logic    from_ram_d;
	logic    clear;
	logic    wr_en;
	addr_t   wr_addr;
	addr_t   rd_addr;
	status_t st;

	assign cmd.ready = !out_valid_q || rsp.ready;
	assign accept    = cmd.valid && cmd.ready;

	assign rsp.valid      = out_valid_q;
	assign rsp.status     = status_q;
	assign rsp.slot_out   = slot_out_q;
	assign rsp.used_count = used_out_q;

	fsfl_ram #(
		.WIDTH(LINK_W),
		.DEPTH(MAX_SLOTS)
	) u_link_ram (
		.clk  (clk),
		.we   (wr_en),
		.waddr(wr_addr),
		.wdata(head_q),
		.raddr(rd_addr),
		.rdata(rd_data)
	);

	// A link that was never written reads as its index plus one; a head past
	// the table has no link and reads as zero.
	always_comb begin
		if (rd_beyond_q) begin
			ram_link = '0;
		end else if (rd_vld_q) begin
			ram_link = rd_data;
		end else begin
			ram_link = LINK_W'(rd_addr_q) + LINK_W'(1);
		end
		link_cur = from_ram_q ? ram_link : link_q;
	end

	always_comb begin
		head_d     = head_q;
		link_d     = link_cur;
		used_d     = used_q;
		from_ram_d = 1'b0;
		got        = '0;
		st         = ST_OK;
		wr_en      = 1'b0;
		wr_addr    = addr_t'(cmd.slot_in);
		rd_addr    = addr_t'(link_cur);
		clear      = cfg_we;
		if (accept) begin
			unique case (cmd.command)
				CMD_ALLOC: begin
					if (used_q >= count_q) begin
						st = ST_EXHAUSTED;
					end else begin
						got        = head_q;
						head_d     = link_cur;
						from_ram_d = 1'b1;
						used_d     = used_q + LINK_W'(1);
					end
				end
				CMD_FREE: begin
					if (used_q == '0) begin
						st = ST_NONE_USED;
					end else if (CMP_W'(cmd.slot_in) >= CMP_W'(count_q)) begin
						st = ST_RANGE;
					end else begin
						wr_en  = 1'b1;
						head_d = LINK_W'(cmd.slot_in);
						link_d = head_q;
						used_d = used_q - LINK_W'(1);
					end
				end
				CMD_REINIT: begin
					clear = 1'b1;
				end
				default: begin
				end
			endcase
		end
		if (clear) begin
			head_d     = '0;
			link_d     = LINK_W'(1);
			used_d     = '0;
			from_ram_d = 1'b0;
		end
	end

	always_comb begin
		if (cfg_wdata == '0) begin
			count_d = LINK_W'(1);
		end else if (32'(cfg_wdata) > MAX_SLOTS) begin
			count_d = LINK_W'(MAX_SLOTS);
		end else begin
			count_d = LINK_W'(cfg_wdata);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= LINK_W'(MAX_SLOTS);
			used_q      <= '0;
			head_q      <= '0;
			link_q      <= LINK_W'(1);
			from_ram_q  <= 1'b0;
			valid_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				count_q <= count_d;
			end
			used_q     <= used_d;
			head_q     <= head_d;
			link_q     <= link_d;
			from_ram_q <= from_ram_d;
			if (clear) begin
				valid_q <= '0;
			end else if (wr_en) begin
				valid_q[wr_addr] <= 1'b1;
			end
			if (accept) begin
				out_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		rd_vld_q    <= valid_q[rd_addr];
		rd_addr_q   <= rd_addr;
		rd_beyond_q <= (link_cur >= LINK_W'(MAX_SLOTS));
		if (accept) begin
			status_q   <= st;
			slot_out_q <= SLOT_OUT_W'(got);
			used_out_q <= USED_W'(used_d);
		end
	end

	a_used_within_count: assert property (@(posedge clk) disable iff (!arst_n)
		used_q <= count_q)
		else $error("allocated slot count exceeds the pool size");

	a_accept_gives_beat: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> out_valid_q)
		else $error("accepted command produced no response beat");

	a_prefetch_after_alloc: assert property (@(posedge clk) disable iff (!arst_n)
		from_ram_q |-> $past(accept && cmd.command == CMD_ALLOC))
		else $error("head link taken from RAM without a preceding allocate");

	a_head_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		head_q <= LINK_W'(MAX_SLOTS))
		else $error("free-list head beyond the table");

endmodule

// ----- tb/fixed_slot_free_list_allocator_tb.sv -----
`timescale 1ns / 100ps
// Self-checking testbench of fixed_slot_free_list_allocator: random and directed commands
// are checked beat by beat against a free-list predictor kept inside the bench.
// Depends on fsfl_pkg, the fsfl_cmd_if/fsfl_rsp_if interfaces and the allocator RTL.
module fixed_slot_free_list_allocator_tb;
	import fsfl_pkg::*;

	localparam int   LIMIT   = 400000;
	localparam int   PLAN    = 0;  // pool view used while generating commands
	localparam int   LIVE    = 1;  // pool view advanced on accepted beats
	localparam cmd_t CMD_NOP = 2'd3;

	typedef logic [SLOT_IN_W-1:0] slot_t;

	typedef struct packed {
		cmd_t  command;
		slot_t slot_in;
	} cmd_beat_t;

	typedef struct packed {
		status_t               status;
		logic [SLOT_OUT_W-1:0] slot_out;
		logic [USED_W-1:0]     used_count;
	} rsp_beat_t;

	logic clk;
	logic arst_n;
	logic cfg_we;
	logic [CFG_W-1:0] cfg_wdata;

	fsfl_cmd_if cmd_ch();
	fsfl_rsp_if rsp_ch();

	fixed_slot_free_list_allocator dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.cmd       (cmd_ch),
		.rsp       (rsp_ch)
	);

	// Two copies of the pool: one to plan well-formed traffic, one to predict responses.
	link_t             pool_link [2][MAX_SLOTS];
	link_t             pool_head [2];
	logic [USED_W-1:0] pool_used [2];
	logic [CFG_W-1:0]  pool_slots [2];

	cmd_beat_t pending_cmds[$];
	rsp_beat_t expected_beats[$];
	slot_t     held_slots[$];

	int cycles;
	int errors;
	int cmds_accepted;
	int grants;
	int exhausted;
	int rejected_frees;
	int burst_left;
	int gap_left;
	logic [9:0] stall_cycle;

	function automatic void pool_rebuild(input int v);
		for (int i = 0; i < MAX_SLOTS; i++)
			pool_link[v][i] = link_t'(i + 1);
		pool_head[v] = '0;
		pool_used[v] = '0;
	endfunction

	function automatic void pool_configure(input int v, input logic [CFG_W-1:0] val);
		pool_slots[v] = val;
		pool_rebuild(v);
	endfunction

	function automatic rsp_beat_t pool_step(input int v, input cmd_t c, input slot_t s);
		rsp_beat_t r;
		int cnt;
		r = '0;
		r.status = ST_OK;
		cnt = pool_slots[v];
		if (cnt < 1)
			cnt = 1;
		if (cnt > MAX_SLOTS)
			cnt = MAX_SLOTS;
		case (c)
			CMD_ALLOC: begin
				if (pool_used[v] >= cnt) begin
					r.status = ST_EXHAUSTED;
				end else begin
					r.slot_out = pool_head[v][SLOT_OUT_W-1:0];
					// A head past the table has no link entry; the next head reads as 0.
					pool_head[v] = (pool_head[v] < MAX_SLOTS) ?
						pool_link[v][pool_head[v][SLOT_W-1:0]] : '0;
					pool_used[v] = pool_used[v] + 1'b1;
				end
			end
			CMD_FREE: begin
				if (pool_used[v] == 0) begin
					r.status = ST_NONE_USED;
				end else if (s >= cnt) begin
					r.status = ST_RANGE;
				end else begin
					pool_link[v][s] = pool_head[v];
					pool_head[v] = link_t'(s);
					pool_used[v] = pool_used[v] - 1'b1;
				end
			end
			CMD_REINIT: begin
				pool_rebuild(v);
			end
			default: begin
			end
		endcase
		r.used_count = pool_used[v];
		return r;
	endfunction

	task automatic queue_cmd(input cmd_t c, input slot_t s);
		rsp_beat_t r;
		int hits[$];
		r = pool_step(PLAN, c, s);
		if (c == CMD_ALLOC && r.status == ST_OK) begin
			held_slots.push_back(r.slot_out);
		end else if (c == CMD_REINIT) begin
			held_slots.delete();
		end else if (c == CMD_FREE && r.status == ST_OK) begin
			hits = held_slots.find_first_index(x) with (x == s);
			if (hits.size() != 0)
				held_slots.delete(hits[0]);
		end
		pending_cmds.push_back('{c, s});
	endtask

	// Mostly allocates and frees of slots the plan says are held; the rest is raw noise.
	task automatic queue_random(input int alloc_pct, input int noise_pct);
		int roll;
		int pick;
		roll = $urandom_range(99);
		if (roll < noise_pct) begin
			queue_cmd(cmd_t'($urandom_range(3)), slot_t'($urandom_range(255)));
		end else if (roll < noise_pct + alloc_pct || held_slots.size() == 0) begin
			queue_cmd(CMD_ALLOC, slot_t'($urandom_range(255)));
		end else begin
			pick = $urandom_range(held_slots.size() - 1);
			queue_cmd(CMD_FREE, held_slots[pick]);
		end
	endtask

	// Returns once every queued command has been answered and the block has settled.
	task automatic wait_idle();
		do
			@(negedge clk);
		while (pending_cmds.size() != 0 || expected_beats.size() != 0 || cmd_ch.valid);
		repeat (4) @(negedge clk);
	endtask

	task automatic write_pool_slots(input logic [CFG_W-1:0] val);
		@(posedge clk);
		cfg_we    <= 1'b1;
		cfg_wdata <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		pool_configure(PLAN, val);
		pool_configure(LIVE, val);
		held_slots.delete();
		@(negedge clk);
	endtask

	// A negative setting keeps the current pool and only drains the pipeline.
	task automatic run_phase(input int setting, input int n, input int alloc_pct,
		input int noise_pct);
		wait_idle();
		if (setting >= 0)
			write_pool_slots(CFG_W'(setting));
		repeat (n) queue_random(alloc_pct, noise_pct);
	endtask

	initial clk = 1'b0;
	always #1 clk = ~clk;

	always @(posedge clk) begin
		cycles++;
		if (cycles > LIMIT) begin
			$display("Timeout after %0d cycles with %0d responses outstanding", cycles,
				expected_beats.size());
			$display("** fixed_slot_free_list_allocator: FAILED **");
			$finish;
		end
	end

	// Command driver: bursts of beats separated by random gaps.
	always @(posedge clk) begin
		cmd_beat_t next_cmd;
		if (arst_n) begin
			if (cmd_ch.valid && cmd_ch.ready) begin
				expected_beats.push_back(pool_step(LIVE, cmd_ch.command, cmd_ch.slot_in));
				cmds_accepted++;
			end
			if (!cmd_ch.valid || cmd_ch.ready) begin
				if (gap_left > 0 || pending_cmds.size() == 0) begin
					if (gap_left > 0)
						gap_left--;
					cmd_ch.valid <= 1'b0;
				end else begin
					next_cmd = pending_cmds.pop_front();
					cmd_ch.valid   <= 1'b1;
					cmd_ch.command <= next_cmd.command;
					cmd_ch.slot_in <= next_cmd.slot_in;
					if (burst_left > 1) begin
						burst_left--;
					end else begin
						burst_left = $urandom_range(1, 24);
						gap_left = ($urandom_range(3) == 0) ? 0 : $urandom_range(1, 6);
					end
				end
			end
		end
	end

	// Response monitor with a stall pattern that cycles through four moods.
	always @(posedge clk) begin
		rsp_beat_t got;
		rsp_beat_t want;
		if (arst_n) begin
			if (rsp_ch.valid && rsp_ch.ready) begin
				got = '{rsp_ch.status, rsp_ch.slot_out, rsp_ch.used_count};
				if (expected_beats.size() == 0) begin
					errors++;
					if (errors <= 10)
						$display("%0t: unexpected beat: status %0d slot %0d used %0d",
							$realtime, got.status, got.slot_out, got.used_count);
				end else begin
					want = expected_beats.pop_front();
					if (got.status !== want.status || got.slot_out !== want.slot_out ||
						got.used_count !== want.used_count) begin
						errors++;
						if (errors <= 10)
							$display("%0t: expected %0d/%0d/%0d, got %0d/%0d/%0d",
								$realtime, want.status, want.slot_out, want.used_count,
								got.status, got.slot_out, got.used_count);
					end
					case (want.status)
						ST_OK:        grants++;
						ST_EXHAUSTED: exhausted++;
						default:      rejected_frees++;
					endcase
				end
			end
			stall_cycle <= stall_cycle + 1'b1;
			case (stall_cycle[9:8])
				2'd0:    rsp_ch.ready <= 1'b1;
				2'd1:    rsp_ch.ready <= ($urandom_range(9) < 7);
				2'd2:    rsp_ch.ready <= ($urandom_range(3) == 0);
				default: rsp_ch.ready <= (stall_cycle[3:0] > 4'd11);
			endcase
		end
	end

	initial begin
		arst_n         = 1'b0;
		cfg_we         = 1'b0;
		cfg_wdata      = '0;
		cmd_ch.valid   = 1'b0;
		cmd_ch.command = CMD_ALLOC;
		cmd_ch.slot_in = '0;
		rsp_ch.ready   = 1'b0;
		stall_cycle    = '0;
		burst_left     = 1;
		gap_left       = 0;
		pool_configure(PLAN, CFG_W'(MAX_SLOTS));
		pool_configure(LIVE, CFG_W'(MAX_SLOTS));
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Default pool: frees with nothing in use, a no-op, a double free and a reinit.
		queue_cmd(CMD_FREE, 8'd0);
		queue_cmd(CMD_FREE, 8'd255);
		queue_cmd(CMD_ALLOC, 8'd0);
		queue_cmd(CMD_NOP, 8'hA5);
		queue_cmd(CMD_ALLOC, 8'hFF);
		queue_cmd(CMD_FREE, 8'd0);
		queue_cmd(CMD_FREE, 8'd0);
		queue_cmd(CMD_REINIT, 8'h5A);
		queue_cmd(CMD_ALLOC, 8'd0);

		// Four slots: run dry, free out of range, then free one slot twice.
		wait_idle();
		write_pool_slots(9'd4);
		repeat (4) queue_cmd(CMD_ALLOC, 8'd0);
		queue_cmd(CMD_ALLOC, 8'd0);
		queue_cmd(CMD_FREE, 8'd4);
		queue_cmd(CMD_FREE, 8'd255);
		queue_cmd(CMD_FREE, 8'd2);
		queue_cmd(CMD_FREE, 8'd2);
		queue_cmd(CMD_ALLOC, 8'd0);
		queue_cmd(CMD_REINIT, 8'd0);
		queue_cmd(CMD_NOP, 8'd0);

		// A count of zero behaves as a single slot.
		wait_idle();
		write_pool_slots(9'd0);
		queue_cmd(CMD_ALLOC, 8'd0);
		queue_cmd(CMD_ALLOC, 8'd0);
		queue_cmd(CMD_FREE, 8'd1);
		queue_cmd(CMD_FREE, 8'd0);

		// An oversize count clamps to the full table; heavy allocation reaches exhaustion.
		run_phase(511, 320, 88, 2);
		run_phase(-1, 150, 40, 4);
		run_phase(1, 60, 50, 10);
		run_phase(17, 200, 55, 6);
		run_phase(2, 80, 50, 10);
		run_phase(256, 200, 50, 4);

		wait_idle();
		repeat (8) @(negedge clk);
		$display("Checked %0d commands over the default pool and seven pool_slots writes",
			cmds_accepted);
		$display("in %0d cycles: %0d ok, %0d exhausted, %0d frees rejected, %0d errors.",
			cycles, grants, exhausted, rejected_frees, errors);
		if (errors == 0 && expected_beats.size() == 0)
			$display("** fixed_slot_free_list_allocator: PASSED **");
		else
			$display("** fixed_slot_free_list_allocator: FAILED **");
		$finish;
	end

endmodule
